// ===== rtl/core/tlb_lookup_clock_replace_macros.svh =====
// Assertion macros for the TLB lookup block.
// Included by the top level; no other dependencies.
`ifndef TLB_LOOKUP_CLOCK_REPLACE_MACROS_SVH
`define TLB_LOOKUP_CLOCK_REPLACE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TLBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlb assertion failed");

// Next-cycle implication, checked outside reset.
`define TLBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlb assertion failed");

`endif

// ===== rtl/core/tlbclk_pkg.sv =====
// Shared types and constants for the TLB lookup block.
// No dependencies.
package tlbclk_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int VPN_W   = 20;
    localparam int PFN_W   = 20;
    localparam int OUT_IDX_W = 4;
    localparam int CNT_W   = 32;

    typedef struct packed {
        logic [VPN_W-1:0] vpn;
        logic             is_write;
        logic [PFN_W-1:0] walk_pfn;
    } req_t;

    typedef struct packed {
        logic [PFN_W-1:0]     pfn;
        logic                 hit;
        logic [OUT_IDX_W-1:0] entry_index;
        logic [CNT_W-1:0]     hit_total;
    } resp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic load;
        logic lookup;
        logic commit;
    } cmd_t;

endpackage

// ===== rtl/core/tlb_lookup_clock_replace.sv =====
// Top level of the fully associative TLB with second-chance replacement.
// Depends on tlbclk_pkg, tlbclk_ctrl, tlbclk_dp and the assertion macros.
//
// Usage:
//   Request channel (req_valid, req_stall, req) carries one access word:
//   vpn, is_write and the frame from the page-table walk. Response channel
//   (resp_valid, resp_stall, resp) returns one word per access: frame, hit
//   flag, entry index and the running hit count.
//   A request is captured into the request register. The lookup step then
//   compares all tags in parallel and runs the victim scan; the update step
//   updates the entry stores and loads the response register.
//   The controller runs each access as a lookup step then an update step
//   and takes no request during the lookup; the next request is taken in
//   the same cycle as the update of the current one.
//   When the receiver stalls, the response register holds its word and the
//   block keeps working until a second finished access has nowhere to go;
//   it then holds in the update step and stalls the request side.
//   Reset clears valid, used and dirty bits, the hit count and all handshake
//   state; tag and frame stores are written on fill only.
`include "tlb_lookup_clock_replace_macros.svh"

module tlb_lookup_clock_replace (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  tlbclk_pkg::req_t    req,
    output logic                resp_valid,
    input  logic                resp_stall,
    output tlbclk_pkg::resp_t   resp
);

    tlbclk_pkg::cmd_t cmd;

    tlbclk_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .resp_valid (resp_valid),
        .resp_stall (resp_stall),
        .cmd        (cmd)
    );

    tlbclk_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .resp  (resp)
    );

    `TLBC_ASSERT_NOW(a_commit_room, clk, rst_n, cmd.commit, !(resp_valid && resp_stall))
    `TLBC_ASSERT_NEXT(a_take_then_lookup, clk, rst_n, req_valid && !req_stall, cmd.lookup)
    `TLBC_ASSERT_NOW(a_lookup_blocks_req, clk, rst_n, cmd.lookup, req_stall && !cmd.commit)
    `TLBC_ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, resp_valid)

endmodule

// ===== rtl/core/tlbclk_ctrl.sv =====
// Controller for the TLB lookup block: access sequencing and handshakes.
// Depends on tlbclk_pkg.
module tlbclk_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    output logic                resp_valid,
    input  logic                resp_stall,
    output tlbclk_pkg::cmd_t    cmd
);

    tlbclk_pkg::state_t state_reg;
    tlbclk_pkg::state_t state_next;
    logic               resp_valid_reg;
    logic               resp_valid_next;
    logic               out_free;
    logic               take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tlbclk_pkg::ST_IDLE;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            resp_valid_reg <= resp_valid_next;
        end
    end

    always_comb
    begin
        out_free    = !resp_valid_reg || !resp_stall;
        cmd.commit  = (state_reg == tlbclk_pkg::ST_UPDATE) && out_free;
        cmd.lookup  = (state_reg == tlbclk_pkg::ST_LOOKUP);
        req_stall   = !((state_reg == tlbclk_pkg::ST_IDLE) || cmd.commit);
        take        = req_valid && !req_stall;
        cmd.load    = take;
        state_next  = state_reg;
        unique case (state_reg)
            tlbclk_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    state_next = tlbclk_pkg::ST_LOOKUP;
                end
            end
            tlbclk_pkg::ST_LOOKUP:
            begin
                state_next = tlbclk_pkg::ST_UPDATE;
            end
            tlbclk_pkg::ST_UPDATE:
            begin
                if (cmd.commit)
                begin
                    state_next = take ? tlbclk_pkg::ST_LOOKUP : tlbclk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlbclk_pkg::ST_IDLE;
            end
        endcase
        resp_valid_next = cmd.commit || (resp_valid_reg && resp_stall);
    end

    assign resp_valid = resp_valid_reg;

endmodule

// ===== rtl/core/tlbclk_dp.sv =====
// Datapath for the TLB lookup block: entry stores, tag compare, victim scan,
// hit counter and result register. Depends on tlbclk_pkg.
module tlbclk_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  tlbclk_pkg::cmd_t    cmd,
    input  tlbclk_pkg::req_t    req,
    output tlbclk_pkg::resp_t   resp
);

    localparam int N  = tlbclk_pkg::ENTRIES;
    localparam int IW = tlbclk_pkg::IDX_W;

    tlbclk_pkg::req_t               req_reg;
    tlbclk_pkg::resp_t              resp_reg;
    logic [N-1:0]                   valid_reg;
    logic [N-1:0]                   used_reg;
    logic [N-1:0]                   dirty_reg;
    logic [tlbclk_pkg::VPN_W-1:0]   tag_mem [N];
    logic [tlbclk_pkg::PFN_W-1:0]   frame_mem [N];
    logic [tlbclk_pkg::CNT_W-1:0]   count_reg;

    logic                           hit_reg;
    logic [IW-1:0]                  idx_reg;
    logic [N-1:0]                   clr_reg;

    logic                           hit_next;
    logic [IW-1:0]                  idx_next;
    logic [N-1:0]                   clr_next;
    logic [N-1:0]                   match;
    logic [IW-1:0]                  hit_idx;
    logic [IW-1:0]                  vic_idx;
    logic                           vic_found;
    logic [IW+tlbclk_pkg::OUT_IDX_W-1:0] idx_ext;

    always_comb
    begin
        hit_next  = 1'b0;
        hit_idx   = '0;
        vic_idx   = '0;
        vic_found = 1'b0;
        clr_next  = '0;
        for (int e = 0; e < N; e++)
        begin
            match[e] = valid_reg[e] && (tag_mem[e] == req_reg.vpn);
            if (!hit_next && match[e])
            begin
                hit_next = 1'b1;
                hit_idx  = IW'(e);
            end
            if (!vic_found)
            begin
                if (!valid_reg[e] || !used_reg[e])
                begin
                    vic_found = 1'b1;
                    vic_idx   = IW'(e);
                end
                else
                begin
                    clr_next[e] = 1'b1;
                end
            end
        end
        idx_next = hit_next ? hit_idx : vic_idx;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.lookup)
        begin
            hit_reg <= hit_next;
            idx_reg <= idx_next;
            clr_reg <= clr_next;
        end
        if (cmd.commit && !hit_reg)
        begin
            tag_mem[idx_reg]   <= req_reg.vpn;
            frame_mem[idx_reg] <= req_reg.walk_pfn;
        end
        if (cmd.commit)
        begin
            resp_reg.hit         <= hit_reg;
            resp_reg.entry_index <= idx_ext[tlbclk_pkg::OUT_IDX_W-1:0];
            resp_reg.pfn         <= hit_reg ? frame_mem[idx_reg] : req_reg.walk_pfn;
            resp_reg.hit_total   <= hit_reg ? count_reg + 1'b1 : count_reg;
        end
    end

    assign idx_ext = {{tlbclk_pkg::OUT_IDX_W{1'b0}}, idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            used_reg  <= '0;
            dirty_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (hit_reg)
            begin
                count_reg         <= count_reg + 1'b1;
                used_reg[idx_reg] <= 1'b1;
                if (req_reg.is_write)
                begin
                    dirty_reg[idx_reg] <= 1'b1;
                end
            end
            else
            begin
                used_reg           <= (used_reg & ~clr_reg) | (N'(1) << idx_reg);
                valid_reg[idx_reg] <= 1'b1;
                dirty_reg[idx_reg] <= req_reg.is_write;
            end
        end
    end

    assign resp = resp_reg;

endmodule
